@@ rtl/core/sesu_pkg.sv @@
`default_nettype none

package sesu_pkg;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_SHORT   = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;
  localparam logic [1:0] STATUS_NONE    = 2'd3;

  localparam logic [2:0] REG_SLICE_COUNT    = 3'd0;
  localparam logic [2:0] REG_ROWS_PER_SLICE = 3'd1;
  localparam logic [2:0] REG_ROWS_TOTAL     = 3'd2;
  localparam logic [2:0] REG_COLUMNS        = 3'd3;
  localparam logic [2:0] REG_BANDS          = 3'd4;
  localparam logic [2:0] REG_MAX_PRECINCT   = 3'd5;

  localparam int unsigned CFG_WIDTH  = 20;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [15:0] SLICE_HEADER_MARKER = 16'hFF20;
  localparam logic [15:0] MIN_HEADER_LEN      = 16'd4;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start_scan;
    logic        last_available;
    logic [15:0] slice_number;
  } scan_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] slice_bytes;
  } scan_out_t;

endpackage

`default_nettype wire

@@ rtl/core/slice_extent_scanner_unit.sv @@
`default_nettype none

// Byte-stream slice scanner: takes one codestream byte per cycle while not stalled, and
// returns one result (complete with the slice length, too short, or invalid) on the
// byte that decides it. Results pass through a two-entry output buffer, so input is
// stalled only while both entries are full. The expected precinct count is built from
// the configuration registers and the requested slice by a three-stage multiply
// pipeline that settles after the byte carrying start_scan, well before the first
// precinct can close. Configuration registers are written by index with the write
// enable; indexes beyond the last register are ignored.
module slice_extent_scanner_unit (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  sesu_pkg::scan_in_t           in_data,
  output logic                               out_valid,
  input  wire                                out_stall,
  output sesu_pkg::scan_out_t                out_data,
  input  wire                                cfg_we,
  input  wire  [sesu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [sesu_pkg::CFG_WIDTH-1:0]     cfg_data
);
  import sesu_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_MARK_HI,
    PH_MARK_LO,
    PH_HLEN_HI,
    PH_HLEN_LO,
    PH_IDX_HI,
    PH_IDX_LO,
    PH_HSKIP,
    PH_PLEN_LO,
    PH_PSKIP
  } phase_t;

  logic [15:0] slice_count;
  logic [15:0] rows_per_slice;
  logic [15:0] rows_total;
  logic [15:0] columns;
  logic [7:0]  bands;
  logic [19:0] max_precinct;

  phase_t      phase, phase_next;
  logic [31:0] offset, offset_next;
  logic [24:0] skip, skip_next;
  logic [23:0] field, field_next;
  logic        seen, seen_next;
  logic [15:0] wanted;
  logic [31:0] done_cnt, done_next;

  logic        last_hit;
  logic [31:0] last_base;
  logic [31:0] rows_sel;
  logic [31:0] expected;
  logic [31:0] last_index;
  logic [31:0] base_prod;
  logic [31:0] count_prod;

  phase_t      cur_phase;
  logic [31:0] cur_offset;
  logic        cur_seen;
  logic [31:0] cur_done;
  logic [15:0] mark16;
  logic [15:0] len16;
  logic [15:0] idx16;
  logic [23:0] plen24;
  logic [6:0]  flag_bytes;
  logic [9:0]  flag_bits;
  logic [1:0]  verdict;

  logic        acc;
  logic        fire;
  logic        take;
  scan_out_t   result;
  scan_out_t   skid;
  logic        skid_valid;

  assign acc      = in_valid & ~in_stall;
  assign in_stall = skid_valid;
  assign take     = out_valid & ~out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      slice_count    <= 16'd1;
      rows_per_slice <= 16'd1;
      rows_total     <= 16'd1;
      columns        <= 16'd1;
      bands          <= 8'd0;
      max_precinct   <= 20'hFFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SLICE_COUNT:    slice_count    <= cfg_data[15:0];
        REG_ROWS_PER_SLICE: rows_per_slice <= cfg_data[15:0];
        REG_ROWS_TOTAL:     rows_total     <= cfg_data[15:0];
        REG_COLUMNS:        columns        <= cfg_data[15:0];
        REG_BANDS:          bands          <= cfg_data[7:0];
        REG_MAX_PRECINCT:   max_precinct   <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // Expected precinct count pipeline.
  assign last_index = {16'd0, slice_count} - 32'd1;
  assign base_prod  = last_index * {16'd0, rows_per_slice};
  assign count_prod = rows_sel * {16'd0, columns};

  always_ff @(posedge clk) begin
    last_hit  <= ({16'd0, wanted} == last_index);
    last_base <= base_prod;
    rows_sel  <= last_hit ? ({16'd0, rows_total} - last_base) : {16'd0, rows_per_slice};
    expected  <= count_prod;
  end

  assign flag_bits  = {1'b0, bands, 1'b0} + 10'd7;
  assign flag_bytes = flag_bits[9:3];

  always_comb begin
    cur_phase  = in_data.start_scan ? PH_MARK_HI : phase;
    cur_offset = in_data.start_scan ? 32'd0 : offset;
    cur_seen   = in_data.start_scan ? 1'b0 : seen;
    cur_done   = in_data.start_scan ? 32'd0 : done_cnt;

    mark16 = {field[7:0], in_data.data_byte};
    len16  = {skip[7:0], in_data.data_byte};
    idx16  = {field[7:0], in_data.data_byte};
    plen24 = {field[15:0], in_data.data_byte};

    phase_next  = cur_phase;
    offset_next = cur_offset + 32'd1;
    skip_next   = skip;
    field_next  = field;
    seen_next   = cur_seen;
    done_next   = cur_done;
    verdict     = STATUS_NONE;

    case (cur_phase)
      PH_MARK_HI: begin
        field_next = {16'd0, in_data.data_byte};
        phase_next = PH_MARK_LO;
      end
      PH_MARK_LO: begin
        field_next = {8'd0, mark16};
        if (mark16 == SLICE_HEADER_MARKER) begin
          if (cur_seen) begin
            verdict = STATUS_INVALID;
          end else begin
            seen_next  = 1'b1;
            phase_next = PH_HLEN_HI;
          end
        end else if (!cur_seen || mark16[15:12] != 4'd0) begin
          verdict = STATUS_INVALID;
        end else begin
          phase_next = PH_PLEN_LO;
        end
      end
      PH_HLEN_HI: begin
        skip_next  = {17'd0, in_data.data_byte};
        phase_next = PH_HLEN_LO;
      end
      PH_HLEN_LO: begin
        skip_next  = {9'd0, len16};
        phase_next = PH_IDX_HI;
      end
      PH_IDX_HI: begin
        field_next = {16'd0, in_data.data_byte};
        phase_next = PH_IDX_LO;
      end
      PH_IDX_LO: begin
        field_next = {8'd0, idx16};
        if (skip[15:0] < MIN_HEADER_LEN || idx16 != wanted) begin
          verdict = STATUS_INVALID;
        end else begin
          skip_next  = skip - 25'd4;
          phase_next = (skip[15:0] != MIN_HEADER_LEN) ? PH_HSKIP : PH_MARK_HI;
        end
      end
      PH_HSKIP: begin
        skip_next = skip - 25'd1;
        if (skip == 25'd1) begin
          phase_next = PH_MARK_HI;
        end
      end
      PH_PLEN_LO: begin
        field_next = plen24;
        if (plen24 > {4'd0, max_precinct}) begin
          verdict = STATUS_INVALID;
        end else begin
          skip_next  = {1'b0, plen24} + 25'd2 + {18'd0, flag_bytes};
          phase_next = PH_PSKIP;
        end
      end
      PH_PSKIP: begin
        skip_next = skip - 25'd1;
        if (skip == 25'd1) begin
          done_next = cur_done + 32'd1;
          if (done_next == expected) begin
            verdict = STATUS_DONE;
          end else begin
            phase_next = PH_MARK_HI;
          end
        end
      end
      default: begin
        phase_next  = PH_IDLE;
        offset_next = cur_offset;
      end
    endcase

    if (cur_phase != PH_IDLE && verdict == STATUS_NONE && in_data.last_available) begin
      verdict = STATUS_SHORT;
    end
    if (verdict != STATUS_NONE) begin
      phase_next = PH_IDLE;
    end

    result.status      = verdict;
    result.slice_bytes = (verdict == STATUS_DONE) ? offset_next : 32'd0;
  end

  assign fire = acc && cur_phase != PH_IDLE && verdict != STATUS_NONE;

  // Scan state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      offset   <= 32'd0;
      skip     <= 25'd0;
      field    <= 24'd0;
      seen     <= 1'b0;
      wanted   <= 16'd0;
      done_cnt <= 32'd0;
    end else if (acc) begin
      if (in_data.start_scan) begin
        wanted <= in_data.slice_number;
      end
      phase    <= phase_next;
      offset   <= offset_next;
      skip     <= skip_next;
      field    <= field_next;
      seen     <= seen_next;
      done_cnt <= done_next;
    end
  end

  // Two-entry result buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (fire) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_data <= skid;
      end
    end else if (fire) begin
      if (!out_valid || take) begin
        out_data <= result;
      end else begin
        skid <= result;
      end
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status != STATUS_NONE)
    else $error("result carries no status");

  a_bytes_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != STATUS_DONE |-> out_data.slice_bytes == 32'd0)
    else $error("slice length reported on a failed scan");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PSKIP || phase == PH_HSKIP) |-> skip != 25'd0)
    else $error("skip counter empty while skipping");

  a_fire_lands: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("result lost");

endmodule

`default_nettype wire
